FILE: rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

    // Pool geometry
    localparam int NUM_PAGES       = 16;
    localparam int PAGE_BYTES      = 8192;
    localparam int MIN_BLOCK_BYTES = 32;

    // Field widths of the block's ports
    localparam int ADDR_W = 17;
    localparam int SIZE_W = 14;
    localparam int HDR_W  = 7;

    // Derived geometry
    localparam int PAGE_W        = $clog2(PAGE_BYTES);
    localparam int MIN_W         = $clog2(MIN_BLOCK_BYTES);
    localparam int LEVELS        = PAGE_W - MIN_W;
    localparam int NODE_W        = LEVELS + 1;
    localparam int DEPTH_W       = $clog2(LEVELS + 1);
    localparam int LEAF_COUNT    = PAGE_BYTES / MIN_BLOCK_BYTES;
    localparam int CNT_W         = $clog2(LEAF_COUNT + 1);
    localparam int WORD_BITS     = 32;
    localparam int BIT_W         = $clog2(WORD_BITS);
    localparam int ROWS_PER_PAGE = (2 * LEAF_COUNT) / WORD_BITS;
    localparam int ROW_W         = $clog2(ROWS_PER_PAGE);
    localparam int PG_W          = $clog2(NUM_PAGES);
    localparam int PGC_W         = $clog2(NUM_PAGES + 1);
    localparam int MAP_ROWS      = NUM_PAGES * ROWS_PER_PAGE;
    localparam int MAP_AW        = PG_W + ROW_W;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_TOO_LARGE = 2'd1,
        STS_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_HEADER_BYTES = 1'b0,
        CFG_MAX_REQUEST  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_SRCH_PG,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_OPEN,
        S_TAKE_RD,
        S_TAKE_WR,
        S_CLASH_RD,
        S_CLASH_CHK,
        S_MERGE_RD,
        S_MERGE_WR,
        S_FREE_CNT,
        S_DONE
    } t_state;

    // Access request from the sequencer to the free map store
    typedef struct packed {
        logic                 rd_en;
        logic [MAP_AW-1:0]    rd_row;
        logic                 wr_en;
        logic [MAP_AW-1:0]    wr_row;
        logic [WORD_BITS-1:0] wr_data;
        logic                 clr_en;
        logic [PG_W-1:0]      clr_page;
    } t_map_req;

endpackage

`default_nettype wire

FILE: rtl/pba_map_store.sv
`default_nettype none

module pba_map_store (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire pba_pkg::t_map_req               i_req,
    output logic [pba_pkg::WORD_BITS-1:0]        o_rdata
);

    logic [pba_pkg::WORD_BITS-1:0] r_mem [pba_pkg::MAP_ROWS];
    logic [pba_pkg::MAP_ROWS-1:0]  r_vld;
    logic [pba_pkg::WORD_BITS-1:0] r_rd_data;
    logic                          r_rd_vld;

    // Write one row, read one row with registered data
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_row];
        end
    end

    // Row valid bits: a row never written since its page was retired reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_row] <= 1'b1;
            end
            if (i_req.clr_en) begin
                for (int i = 0; i < pba_pkg::ROWS_PER_PAGE; i++) begin
                    r_vld[{i_req.clr_page, pba_pkg::ROW_W'(i)}] <= 1'b0;
                end
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_row];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: rtl/paged_buddy_allocator.sv
`default_nettype none

// Buddy allocator over 16 pages of 8 KiB with blocks of 32 bytes up to a page.
// One transaction is taken at a time: o_in_ready is high only while the
// sequencer is idle, and a finished result waits in the output register while
// the next transaction is taken. The free map lives in one memory
// of 32-bit rows (16 rows per page), so the rate is set by row accesses, each
// row read or read-modify-write taking a read state and a check or write state.
// A free that meets no overlap scans the page row by row for overlap, then does
// a read-modify-write per merge level, plus set-up; an overlap found early cuts
// the scan short. An allocate steps over each page and level passed over, reads
// each searched row and does a read-modify-write per split level, so it grows
// with the number of open pages and their fragmentation.
// Row valid bits, cleared at reset and whenever a page is opened or retired,
// make any clearing pass unnecessary. Write configuration only while idle.
module paged_buddy_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [pba_pkg::SIZE_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_cmd,
    input  wire logic [pba_pkg::SIZE_W-1:0]    i_request_bytes,
    input  wire logic [pba_pkg::ADDR_W-1:0]    i_block_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [pba_pkg::ADDR_W-1:0]         o_granted_address,
    output logic [pba_pkg::SIZE_W-1:0]         o_granted_bytes,
    output logic [1:0]                         o_status
);

    typedef struct packed {
        logic                          ok;
        logic [pba_pkg::SIZE_W-1:0]    size;
        logic [pba_pkg::DEPTH_W-1:0]   depth;
    } t_round;

    localparam int NEED_W = pba_pkg::SIZE_W + 1;
    localparam int FPG_W  = pba_pkg::ADDR_W - pba_pkg::PAGE_W;

    // Round request plus header up to a block size; depth of that level
    function automatic t_round round_size(input logic [pba_pkg::SIZE_W-1:0] req,
                                          input logic [pba_pkg::HDR_W-1:0] hdr);
        logic [NEED_W-1:0] need;
        t_round            r;
        need = {1'b0, req} + NEED_W'(hdr);
        r    = '0;
        for (int k = pba_pkg::LEVELS; k >= 0; k--) begin
            if (need <= NEED_W'(pba_pkg::MIN_BLOCK_BYTES << k)) begin
                r.ok    = 1'b1;
                r.size  = pba_pkg::SIZE_W'(pba_pkg::MIN_BLOCK_BYTES << k);
                r.depth = pba_pkg::DEPTH_W'(pba_pkg::LEVELS - k);
            end
        end
        return r;
    endfunction

    function automatic logic [pba_pkg::DEPTH_W-1:0] node_depth(
        input logic [pba_pkg::NODE_W-1:0] m);
        logic [pba_pkg::DEPTH_W-1:0] d;
        d = '0;
        for (int i = 0; i < pba_pkg::NODE_W; i++) begin
            if (m[i]) d = pba_pkg::DEPTH_W'(i);
        end
        return d;
    endfunction

    // Bits of a row that are nodes of level d
    function automatic logic [pba_pkg::WORD_BITS-1:0] level_mask(
        input logic [pba_pkg::ROW_W-1:0]   row,
        input logic [pba_pkg::DEPTH_W-1:0] d);
        logic [pba_pkg::WORD_BITS-1:0] mk;
        logic [pba_pkg::NODE_W-1:0]    m;
        mk = '0;
        for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
            m     = {row, pba_pkg::BIT_W'(b)};
            mk[b] = ((m >> d) == pba_pkg::NODE_W'(1));
        end
        return mk;
    endfunction

    // Bits of a row that are node n, its ancestors or its descendants
    function automatic logic [pba_pkg::WORD_BITS-1:0] line_mask(
        input logic [pba_pkg::ROW_W-1:0]   row,
        input logic [pba_pkg::NODE_W-1:0]  n,
        input logic [pba_pkg::DEPTH_W-1:0] dt);
        logic [pba_pkg::WORD_BITS-1:0] mk;
        logic [pba_pkg::NODE_W-1:0]    m;
        logic [pba_pkg::DEPTH_W-1:0]   dm;
        mk = '0;
        for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
            m  = {row, pba_pkg::BIT_W'(b)};
            dm = node_depth(m);
            if (m == '0) begin
                mk[b] = 1'b0;
            end else if (dm <= dt) begin
                mk[b] = ((n >> (dt - dm)) == m);
            end else begin
                mk[b] = ((m >> (dm - dt)) == n);
            end
        end
        return mk;
    endfunction

    // Lowest set bit of a row: {hit, index}
    function automatic logic [pba_pkg::BIT_W:0] lowest_bit(
        input logic [pba_pkg::WORD_BITS-1:0] w);
        logic [pba_pkg::BIT_W:0] r;
        r = '0;
        for (int i = pba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) r = {1'b1, pba_pkg::BIT_W'(i)};
        end
        return r;
    endfunction

    function automatic logic [pba_pkg::ROW_W-1:0] row_first(
        input logic [pba_pkg::DEPTH_W-1:0] d);
        if (int'(d) < pba_pkg::BIT_W) return '0;
        return pba_pkg::ROW_W'(1 << (int'(d) - pba_pkg::BIT_W));
    endfunction

    function automatic logic [pba_pkg::ROW_W-1:0] row_last(
        input logic [pba_pkg::DEPTH_W-1:0] d);
        if (int'(d) < pba_pkg::BIT_W) return '0;
        return pba_pkg::ROW_W'((2 << (int'(d) - pba_pkg::BIT_W)) - 1);
    endfunction

    pba_pkg::t_state                r_state, n_state;
    logic                           r_cmd;
    logic [pba_pkg::SIZE_W-1:0]     r_req;
    logic [pba_pkg::ADDR_W-1:0]     r_addr;
    logic [pba_pkg::SIZE_W-1:0]     r_size, n_size;
    logic [pba_pkg::DEPTH_W-1:0]    r_dt, n_dt;
    logic [pba_pkg::DEPTH_W-1:0]    r_d, n_d;
    logic [pba_pkg::PGC_W-1:0]      r_pg, n_pg;
    logic [pba_pkg::ROW_W-1:0]      r_row, n_row;
    logic [pba_pkg::NODE_W-1:0]     r_c, n_c;
    logic [pba_pkg::DEPTH_W-1:0]    r_cd, n_cd;
    logic [pba_pkg::NODE_W-1:0]     r_tn, n_tn;
    logic                           r_tv, n_tv;
    logic [pba_pkg::NUM_PAGES-1:0]  r_open, n_open;
    logic [pba_pkg::CNT_W-1:0]      r_cnt [pba_pkg::NUM_PAGES];
    logic [pba_pkg::CNT_W-1:0]      n_cnt;
    logic                           n_cnt_we;
    logic [pba_pkg::ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic [pba_pkg::SIZE_W-1:0]     r_res_bytes, n_res_bytes;
    logic [1:0]                     r_res_status, n_res_status;
    logic                           r_ovld, n_ovld;
    logic [pba_pkg::ADDR_W-1:0]     r_gaddr;
    logic [pba_pkg::SIZE_W-1:0]     r_gbytes;
    logic [1:0]                     r_status;
    logic                           n_load;
    logic [pba_pkg::HDR_W-1:0]      r_hdr;
    logic [pba_pkg::SIZE_W-1:0]     r_max;

    pba_pkg::t_map_req              w_map;
    logic [pba_pkg::WORD_BITS-1:0]  w_rd;
    t_round                         w_rnd;
    logic                           w_big;
    logic [pba_pkg::PAGE_W-1:0]     w_off;
    logic [FPG_W-1:0]               w_fpg;
    logic                           w_free_ok;
    logic [pba_pkg::NODE_W-1:0]     w_fnode;
    logic [pba_pkg::PG_W-1:0]       w_pg;
    logic                           w_pg_end;
    logic                           w_cur_open;
    logic [pba_pkg::BIT_W:0]        w_low;
    logic                           w_hit;
    logic                           w_srch_last;
    logic                           w_clash;
    logic [pba_pkg::BIT_W-1:0]      w_bud_bit;
    logic                           w_merge;
    logic [pba_pkg::WORD_BITS-1:0]  w_cbit;
    logic [pba_pkg::WORD_BITS-1:0]  w_tbit;
    logic [pba_pkg::WORD_BITS-1:0]  w_bbit;
    logic                           w_new_hit;
    logic [pba_pkg::PG_W-1:0]       w_new_pg;
    logic [pba_pkg::NODE_W-1:0]     w_idx;
    logic [pba_pkg::PAGE_W-1:0]     w_goff;
    logic [pba_pkg::CNT_W-1:0]      w_cnt_dec;
    logic                           w_closed_busy;

    pba_map_store u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_map),
        .o_rdata (w_rd)
    );

    // Request decode
    assign w_rnd     = round_size(r_req, r_hdr);
    assign w_big     = (r_req > r_max) || !w_rnd.ok;
    assign w_off     = r_addr[pba_pkg::PAGE_W-1:0];
    assign w_fpg     = r_addr[pba_pkg::ADDR_W-1:pba_pkg::PAGE_W];
    assign w_free_ok = (int'(w_fpg) < pba_pkg::NUM_PAGES)
                    && r_open[pba_pkg::PG_W'(w_fpg)]
                    && ((w_off & pba_pkg::PAGE_W'(w_rnd.size - pba_pkg::SIZE_W'(1))) == '0);
    assign w_fnode   = (pba_pkg::NODE_W'(1) << w_rnd.depth)
                     | pba_pkg::NODE_W'(w_off >> (pba_pkg::PAGE_W - int'(w_rnd.depth)));

    // Search and update helpers
    assign w_pg        = r_pg[pba_pkg::PG_W-1:0];
    assign w_pg_end    = (r_pg == pba_pkg::PGC_W'(pba_pkg::NUM_PAGES));
    assign w_cur_open  = r_open[w_pg];
    assign w_low       = lowest_bit(w_rd & level_mask(r_row, r_d));
    assign w_hit       = w_low[pba_pkg::BIT_W];
    assign w_srch_last = (r_row == row_last(r_d));
    assign w_clash     = |(w_rd & line_mask(r_row, r_c, r_dt));
    assign w_bud_bit   = r_c[pba_pkg::BIT_W-1:0] ^ pba_pkg::BIT_W'(1);
    assign w_merge     = (r_c > pba_pkg::NODE_W'(1)) && w_rd[w_bud_bit];
    assign w_cbit      = pba_pkg::WORD_BITS'(1) << r_c[pba_pkg::BIT_W-1:0];
    assign w_tbit      = pba_pkg::WORD_BITS'(1) << r_tn[pba_pkg::BIT_W-1:0];
    assign w_bbit      = pba_pkg::WORD_BITS'(1) << w_bud_bit;
    assign w_idx       = r_c ^ (pba_pkg::NODE_W'(1) << r_dt);
    assign w_goff      = pba_pkg::PAGE_W'(w_idx) << (pba_pkg::PAGE_W - int'(r_dt));
    assign w_cnt_dec   = (r_cnt[w_pg] == '0) ? '0 : r_cnt[w_pg] - pba_pkg::CNT_W'(1);

    // Lowest page not open
    always_comb begin
        w_new_hit = 1'b0;
        w_new_pg  = '0;
        for (int i = pba_pkg::NUM_PAGES - 1; i >= 0; i--) begin
            if (!r_open[i]) begin
                w_new_hit = 1'b1;
                w_new_pg  = pba_pkg::PG_W'(i);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pba_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pba_pkg::S_EVAL;
            end
            pba_pkg::S_EVAL: begin
                if (w_big) begin
                    n_state = pba_pkg::S_DONE;
                end else if (r_cmd == pba_pkg::CMD_ALLOC) begin
                    n_state = pba_pkg::S_SRCH_PG;
                end else if (w_free_ok) begin
                    n_state = pba_pkg::S_CLASH_RD;
                end else begin
                    n_state = pba_pkg::S_DONE;
                end
            end
            pba_pkg::S_SRCH_PG: begin
                if (w_pg_end) begin
                    if (r_d == '0) n_state = pba_pkg::S_OPEN;
                end else if (w_cur_open) begin
                    n_state = pba_pkg::S_SRCH_RD;
                end
            end
            pba_pkg::S_SRCH_RD:  n_state = pba_pkg::S_SRCH_CHK;
            pba_pkg::S_SRCH_CHK: begin
                if (w_hit)            n_state = pba_pkg::S_TAKE_RD;
                else if (w_srch_last) n_state = pba_pkg::S_SRCH_PG;
                else                  n_state = pba_pkg::S_SRCH_RD;
            end
            pba_pkg::S_OPEN: begin
                n_state = w_new_hit ? pba_pkg::S_TAKE_RD : pba_pkg::S_DONE;
            end
            pba_pkg::S_TAKE_RD: n_state = pba_pkg::S_TAKE_WR;
            pba_pkg::S_TAKE_WR: begin
                n_state = (r_cd == r_dt) ? pba_pkg::S_DONE : pba_pkg::S_TAKE_RD;
            end
            pba_pkg::S_CLASH_RD:  n_state = pba_pkg::S_CLASH_CHK;
            pba_pkg::S_CLASH_CHK: begin
                if (w_clash) begin
                    n_state = pba_pkg::S_DONE;
                end else if (r_row == pba_pkg::ROW_W'(pba_pkg::ROWS_PER_PAGE - 1)) begin
                    n_state = pba_pkg::S_MERGE_RD;
                end else begin
                    n_state = pba_pkg::S_CLASH_RD;
                end
            end
            pba_pkg::S_MERGE_RD: n_state = pba_pkg::S_MERGE_WR;
            pba_pkg::S_MERGE_WR: begin
                n_state = w_merge ? pba_pkg::S_MERGE_RD : pba_pkg::S_FREE_CNT;
            end
            pba_pkg::S_FREE_CNT: n_state = pba_pkg::S_DONE;
            pba_pkg::S_DONE: begin
                if (!r_ovld || i_out_ready) n_state = pba_pkg::S_IDLE;
            end
            default: n_state = pba_pkg::S_IDLE;
        endcase
    end

    // Datapath and map accesses
    always_comb begin
        n_size       = r_size;
        n_dt         = r_dt;
        n_d          = r_d;
        n_pg         = r_pg;
        n_row        = r_row;
        n_c          = r_c;
        n_cd         = r_cd;
        n_tn         = r_tn;
        n_tv         = r_tv;
        n_open       = r_open;
        n_cnt        = r_cnt[w_pg];
        n_cnt_we     = 1'b0;
        n_res_addr   = r_res_addr;
        n_res_bytes  = r_res_bytes;
        n_res_status = r_res_status;
        n_load       = 1'b0;
        w_map        = '0;
        unique case (r_state)
            pba_pkg::S_IDLE: ;
            pba_pkg::S_EVAL: begin
                n_size       = w_rnd.size;
                n_dt         = w_rnd.depth;
                n_d          = w_rnd.depth;
                n_res_addr   = '0;
                n_res_bytes  = '0;
                n_res_status = w_big ? pba_pkg::STS_TOO_LARGE : pba_pkg::STS_OK;
                n_row        = '0;
                n_c          = w_fnode;
                if (r_cmd == pba_pkg::CMD_ALLOC) n_pg = '0;
                else                             n_pg = pba_pkg::PGC_W'(w_fpg);
            end
            pba_pkg::S_SRCH_PG: begin
                if (w_pg_end) begin
                    if (r_d != '0) begin
                        n_d  = r_d - pba_pkg::DEPTH_W'(1);
                        n_pg = '0;
                    end
                end else if (w_cur_open) begin
                    n_row = row_first(r_d);
                end else begin
                    n_pg = r_pg + pba_pkg::PGC_W'(1);
                end
            end
            pba_pkg::S_SRCH_RD: begin
                w_map.rd_en  = 1'b1;
                w_map.rd_row = {w_pg, r_row};
            end
            pba_pkg::S_SRCH_CHK: begin
                if (w_hit) begin
                    n_c  = {r_row, w_low[pba_pkg::BIT_W-1:0]};
                    n_tn = {r_row, w_low[pba_pkg::BIT_W-1:0]};
                    n_cd = r_d;
                    n_tv = 1'b0;
                end else if (w_srch_last) begin
                    n_pg = r_pg + pba_pkg::PGC_W'(1);
                end else begin
                    n_row = r_row + pba_pkg::ROW_W'(1);
                end
            end
            pba_pkg::S_OPEN: begin
                if (w_new_hit) begin
                    n_pg             = pba_pkg::PGC_W'(w_new_pg);
                    n_open[w_new_pg] = 1'b1;
                    w_map.clr_en     = 1'b1;
                    w_map.clr_page   = w_new_pg;
                    n_c              = pba_pkg::NODE_W'(1);
                    n_tn             = pba_pkg::NODE_W'(1);
                    n_cd             = '0;
                    n_tv             = 1'b0;
                end else begin
                    n_res_status = pba_pkg::STS_EXHAUSTED;
                end
            end
            pba_pkg::S_TAKE_RD: begin
                w_map.rd_en  = 1'b1;
                w_map.rd_row = {w_pg, r_tn[pba_pkg::NODE_W-1:pba_pkg::BIT_W]};
            end
            pba_pkg::S_TAKE_WR: begin
                w_map.wr_en   = 1'b1;
                w_map.wr_row  = {w_pg, r_tn[pba_pkg::NODE_W-1:pba_pkg::BIT_W]};
                w_map.wr_data = r_tv ? (w_rd | w_tbit) : (w_rd & ~w_tbit);
                if (r_cd == r_dt) begin
                    n_cnt       = r_cnt[w_pg] + pba_pkg::CNT_W'(1);
                    n_cnt_we    = 1'b1;
                    n_res_addr  = pba_pkg::ADDR_W'({w_pg, w_goff});
                    n_res_bytes = r_size;
                end else begin
                    n_tn = {r_c[pba_pkg::NODE_W-2:0], 1'b1};
                    n_c  = {r_c[pba_pkg::NODE_W-2:0], 1'b0};
                    n_tv = 1'b1;
                    n_cd = r_cd + pba_pkg::DEPTH_W'(1);
                end
            end
            pba_pkg::S_CLASH_RD: begin
                w_map.rd_en  = 1'b1;
                w_map.rd_row = {w_pg, r_row};
            end
            pba_pkg::S_CLASH_CHK: begin
                if (!w_clash && (r_row != pba_pkg::ROW_W'(pba_pkg::ROWS_PER_PAGE - 1))) begin
                    n_row = r_row + pba_pkg::ROW_W'(1);
                end
            end
            pba_pkg::S_MERGE_RD: begin
                w_map.rd_en  = 1'b1;
                w_map.rd_row = {w_pg, r_c[pba_pkg::NODE_W-1:pba_pkg::BIT_W]};
            end
            pba_pkg::S_MERGE_WR: begin
                w_map.wr_en  = 1'b1;
                w_map.wr_row = {w_pg, r_c[pba_pkg::NODE_W-1:pba_pkg::BIT_W]};
                if (w_merge) begin
                    w_map.wr_data = w_rd & ~w_cbit & ~w_bbit;
                    n_c           = r_c >> 1;
                end else begin
                    w_map.wr_data = w_rd | w_cbit;
                end
            end
            pba_pkg::S_FREE_CNT: begin
                n_cnt       = w_cnt_dec;
                n_cnt_we    = 1'b1;
                n_res_bytes = r_size;
                if (w_cnt_dec == '0) begin
                    n_open[w_pg]   = 1'b0;
                    w_map.clr_en   = 1'b1;
                    w_map.clr_page = w_pg;
                end
            end
            pba_pkg::S_DONE: begin
                if (!r_ovld || i_out_ready) n_load = 1'b1;
            end
            default: ;
        endcase
    end

    // Output register valid: set on load, drop when the transaction is taken
    always_comb begin
        n_ovld = r_ovld;
        if (n_load)                         n_ovld = 1'b1;
        else if (r_ovld && i_out_ready)     n_ovld = 1'b0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pba_pkg::S_IDLE;
            r_open  <= '0;
            r_ovld  <= 1'b0;
            r_hdr   <= pba_pkg::HDR_W'(24);
            r_max   <= pba_pkg::SIZE_W'(8000);
            for (int i = 0; i < pba_pkg::NUM_PAGES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_ovld  <= n_ovld;
            if (n_cnt_we) begin
                r_cnt[w_pg] <= n_cnt;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pba_pkg::CFG_HEADER_BYTES: r_hdr <= i_cfg_data[pba_pkg::HDR_W-1:0];
                    pba_pkg::CFG_MAX_REQUEST:  r_max <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        if ((r_state == pba_pkg::S_IDLE) && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_req  <= i_request_bytes;
            r_addr <= i_block_address;
        end
        r_size       <= n_size;
        r_dt         <= n_dt;
        r_d          <= n_d;
        r_pg         <= n_pg;
        r_row        <= n_row;
        r_c          <= n_c;
        r_cd         <= n_cd;
        r_tn         <= n_tn;
        r_tv         <= n_tv;
        r_res_addr   <= n_res_addr;
        r_res_bytes  <= n_res_bytes;
        r_res_status <= n_res_status;
        if (n_load) begin
            r_gaddr  <= r_res_addr;
            r_gbytes <= r_res_bytes;
            r_status <= r_res_status;
        end
    end

    assign o_in_ready        = (r_state == pba_pkg::S_IDLE);
    assign o_out_valid       = r_ovld;
    assign o_granted_address = r_gaddr;
    assign o_granted_bytes   = r_gbytes;
    assign o_status          = r_status;

    // A closed page must hold no blocks in use
    always_comb begin
        w_closed_busy = 1'b0;
        for (int i = 0; i < pba_pkg::NUM_PAGES; i++) begin
            if (!r_open[i] && (r_cnt[i] != '0)) w_closed_busy = 1'b1;
        end
    end

    a_closed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_closed_busy)
        else $error("closed page holds a nonzero use count");

    a_pow2_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_granted_bytes != '0)) |-> $onehot(o_granted_bytes))
        else $error("granted size not a power of two");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == pba_pkg::STS_OK)) |->
        ((o_granted_address[pba_pkg::PAGE_W-1:0]
          & (pba_pkg::PAGE_W'(o_granted_bytes) - pba_pkg::PAGE_W'(1))) == '0))
        else $error("granted block not aligned to its size");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != pba_pkg::STS_OK)) |->
        ((o_granted_bytes == '0) && (o_granted_address == '0)))
        else $error("failed transaction carries a grant");

endmodule

`default_nettype wire
